// ===== design/xoshiro256_random_generator_defines.svh =====
// Assertion helpers used by the generator controller.
// Each expects clk_i and rst_ni to exist in the module that uses it.
`ifndef XOSHIRO256_RANDOM_GENERATOR_DEFINES_SVH
`define XOSHIRO256_RANDOM_GENERATOR_DEFINES_SVH

// same-cycle implication
`define XRG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/xrg_pkg.sv =====
package xrg_pkg;

  // request kinds
  typedef enum logic [2:0] {
    KIND_RAW    = 3'd0,
    KIND_B64    = 3'd1,
    KIND_B32    = 3'd2,
    KIND_J128   = 3'd3,
    KIND_J192   = 3'd4,
    KIND_RESEED = 3'd5
  } xrg_kind_e;

  // register indexes
  typedef enum logic [2:0] {
    REG_VARIANT = 3'd0,
    REG_SEED0   = 3'd1,
    REG_SEED1   = 3'd2,
    REG_SEED2   = 3'd3,
    REG_SEED3   = 3'd4
  } xrg_reg_e;

  // output scramblers
  typedef enum logic [1:0] {
    VAR_PLUS     = 2'd0,
    VAR_PLUSPLUS = 2'd1,
    VAR_STARSTAR = 2'd2
  } xrg_variant_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_JUMP,
    ST_DONE
  } xrg_state_e;

  typedef logic [3:0][63:0] xrg_gen_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;   // capture kind and bound info
    logic draw;        // scramble into candidate, advance state
    logic reseed;      // load seeds and advance
    logic jump_clear;  // clear accumulators and bit counter
    logic jump_step;   // one polynomial bit
    logic out_load;    // load the output word
    logic out_zero;    // output word is zero
  } xrg_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fit;       // shifted candidate below bound, or zero bound
    logic jump_end;  // last polynomial bit
  } xrg_stat_t;

  // jump polynomials, word 0 in the low bits
  localparam logic [255:0] JUMP128_POLY = {
    64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
  };
  localparam logic [255:0] JUMP192_POLY = {
    64'h39109bb02acbe635, 64'h77710069854ee241,
    64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
  };

  // state after reset: seed (1,0,0,0) advanced once
  localparam xrg_gen_t GEN_RESET = {64'd0, 64'd1, 64'd1, 64'd1};

  // one state transition
  function automatic xrg_gen_t xrg_advance(input xrg_gen_t s);
    logic [63:0] t;
    logic [63:0] a0, a1, a2, a3;
    xrg_gen_t r;
    t  = s[1] << 17;
    a2 = s[2] ^ s[0];
    a3 = s[3] ^ s[1];
    a1 = s[1] ^ a2;
    a0 = s[0] ^ a3;
    a2 = a2 ^ t;
    a3 = {a3[18:0], a3[63:19]};
    r  = {a3, a2, a1, a0};
    return r;
  endfunction

  // leading zero count by binary search; zero input gives 63
  function automatic logic [5:0] xrg_clz64(input logic [63:0] v);
    logic [63:0] x;
    logic [5:0] n;
    x = v;
    n = '0;
    if (x[63:32] == '0) begin n[5] = 1'b1; x = x << 32; end
    if (x[63:48] == '0) begin n[4] = 1'b1; x = x << 16; end
    if (x[63:56] == '0) begin n[3] = 1'b1; x = x << 8; end
    if (x[63:60] == '0) begin n[2] = 1'b1; x = x << 4; end
    if (x[63:62] == '0) begin n[1] = 1'b1; x = x << 2; end
    if (x[63] == 1'b0) begin n[0] = 1'b1; end
    return n;
  endfunction

endpackage

// ===== design/xoshiro256_random_generator.sv =====
// xoshiro256 random generator with plus, plus-plus and star-star outputs.
// Request channel (in_valid_i/in_ready_o) carries kind_i and bound_i; each
// request word gives exactly one result word on value_o (out_valid_o/out_ready_i).
// Configuration channel (cfg_valid_i/cfg_ready_o) writes register cfg_index_i:
// 0 output variant, 1..4 seed words; always ready, write only while idle.
// A raw draw takes its candidate at accept and registers the result in the
// output register once the slot is free. Bounded draws redraw on each rejected
// candidate (the draw/compare loop handles one candidate a cycle). Jumps step
// one polynomial bit a cycle over 256 bits. Jump, reseed and unknown kinds return zero.
// A new request is taken while the last result still waits in the output
// register; if the receiver stalls, the next result holds in the datapath
// until the output register frees, and requests are refused meanwhile.
// Reset loads the seed defaults (1,0,0,0) advanced once and selects
// plus-plus; no clearing pass is needed.
module xoshiro256_random_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [63:0] bound_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o
);
  import xrg_pkg::*;

  xrg_cmd_t  cmd;
  xrg_stat_t stat;

  assign cfg_ready_o = 1'b1;

  xrg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  xrg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .kind_i      (kind_i),
    .bound_i     (bound_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .value_o     (value_o)
  );

endmodule

// ===== design/xrg_ctrl.sv =====
`include "xoshiro256_random_generator_defines.svh"

module xrg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        kind_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output xrg_pkg::xrg_cmd_t cmd_o,
  input  xrg_pkg::xrg_stat_t stat_i
);
  import xrg_pkg::*;

  xrg_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;
  logic       accept;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // state and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load_item = 1'b1;
          case (kind_i)
            KIND_RAW, KIND_B64, KIND_B32: begin
              cmd_o.draw = 1'b1;
              state_d    = ST_CHECK;
            end
            KIND_J128, KIND_J192: begin
              cmd_o.jump_clear = 1'b1;
              state_d          = ST_JUMP;
            end
            KIND_RESEED: begin
              cmd_o.reseed = 1'b1;
              state_d      = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_CHECK: begin
        // redraw on reject, else hand over once the slot is free
        if (!stat_i.fit) begin
          cmd_o.draw = 1'b1;
        end else if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_JUMP: begin
        cmd_o.jump_step = 1'b1;
        if (stat_i.jump_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_zero = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  `XRG_ASSERT_NOW(a_load_slot_free, cmd_o.out_load, !out_valid_q || out_ready_i,
                  "output word overwritten while still pending")
  `XRG_ASSERT_NOW(a_state_ops_exclusive, 1'b1,
                  $onehot0({cmd_o.draw, cmd_o.reseed, cmd_o.jump_step, cmd_o.jump_clear}),
                  "conflicting state update commands")
  `XRG_ASSERT_NEXT(a_jump_to_done, (state_q == ST_JUMP) && stat_i.jump_end,
                   state_q == ST_DONE, "jump did not finish after last bit")

endmodule

// ===== design/xrg_datapath.sv =====
module xrg_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic [2:0]         kind_i,
  input  logic [63:0]        bound_i,
  input  xrg_pkg::xrg_cmd_t  cmd_i,
  output xrg_pkg::xrg_stat_t stat_o,
  output logic [63:0]        value_o
);
  import xrg_pkg::*;

  // configuration
  logic [1:0]  variant_q;
  logic [63:0] seed0_q, seed1_q, seed2_q, seed3_q;

  // generator and jump state
  xrg_gen_t    gen_q, gen_d;
  xrg_gen_t    acc_q, acc_d;
  logic [7:0]  cnt_q, cnt_d;

  // per-item registers
  logic        is32_q, sel192_q;
  logic [63:0] bound_q;
  logic [5:0]  shift_q;
  logic [63:0] cand_q;
  logic [63:0] value_q;

  logic [63:0] item_bound;
  logic [5:0]  item_clz;
  logic [5:0]  item_shift;
  logic [63:0] scr;
  logic [63:0] sum03, mul5, rot7;
  logic [63:0] cand_w, shifted;
  logic        poly_bit;
  xrg_gen_t    acc_x;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VAR_PLUSPLUS;
      seed0_q   <= 64'd1;
      seed1_q   <= '0;
      seed2_q   <= '0;
      seed3_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VARIANT: variant_q <= cfg_data_i[1:0];
        REG_SEED0:   seed0_q   <= cfg_data_i;
        REG_SEED1:   seed1_q   <= cfg_data_i;
        REG_SEED2:   seed2_q   <= cfg_data_i;
        REG_SEED3:   seed3_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output scrambler
  always_comb begin
    sum03 = gen_q[0] + gen_q[3];
    mul5  = (gen_q[1] << 2) + gen_q[1];
    rot7  = {mul5[56:0], mul5[63:57]};
    case (variant_q)
      VAR_PLUS:     scr = sum03;
      VAR_PLUSPLUS: scr = {sum03[40:0], sum03[63:41]} + gen_q[0];
      default:      scr = (rot7 << 3) + rot7;
    endcase
  end

  // item bound and shift, zero bound means take the first draw
  always_comb begin
    case (kind_i)
      KIND_B64: item_bound = bound_i;
      KIND_B32: item_bound = {32'd0, bound_i[31:0]};
      default:  item_bound = '0;
    endcase
    item_clz = xrg_clz64(item_bound);
    if (item_bound == '0) item_shift = '0;
    else if (kind_i == KIND_B32) item_shift = {1'b0, item_clz[4:0]};
    else item_shift = item_clz;
  end

  // candidate check
  assign cand_w     = is32_q ? {32'd0, cand_q[31:0]} : cand_q;
  assign shifted    = cand_w >> shift_q;
  assign stat_o.fit = (bound_q == '0) || (shifted < bound_q);

  // jump step
  assign poly_bit        = sel192_q ? JUMP192_POLY[cnt_q] : JUMP128_POLY[cnt_q];
  assign acc_x           = poly_bit ? (acc_q ^ gen_q) : acc_q;
  assign stat_o.jump_end = (cnt_q == 8'hff);

  // state update
  always_comb begin
    gen_d = gen_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (cmd_i.reseed) begin
      gen_d = xrg_advance({seed3_q, seed2_q, seed1_q, seed0_q});
    end else if (cmd_i.draw) begin
      gen_d = xrg_advance(gen_q);
    end else if (cmd_i.jump_clear) begin
      acc_d = '0;
      cnt_d = '0;
    end else if (cmd_i.jump_step) begin
      acc_d = acc_x;
      if (stat_o.jump_end) begin
        gen_d = acc_x;
        cnt_d = '0;
      end else begin
        gen_d = xrg_advance(gen_q);
        cnt_d = cnt_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= GEN_RESET;
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      gen_q <= gen_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      is32_q   <= (kind_i == KIND_B32);
      sel192_q <= (kind_i == KIND_J192);
      bound_q  <= item_bound;
      shift_q  <= item_shift;
    end
    if (cmd_i.draw) cand_q <= scr;
    if (cmd_i.out_load) value_q <= cmd_i.out_zero ? 64'd0 : shifted;
  end

  assign value_o = value_q;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import xrg_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned IDLE_LIMIT      = 4000;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned HOLD_LEN        = 150;
  localparam int unsigned TAIL_CYCLES     = 20;

  // codes outside the package enums
  localparam logic [2:0] KIND_UNDEF6      = 3'd6;
  localparam logic [2:0] KIND_UNDEF7      = 3'd7;
  localparam logic [2:0] REG_UNUSED       = 3'd7;
  localparam logic [1:0] VAR_STARSTAR_ALT = 2'd3;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // jump polynomials, word 0 in the low bits
  localparam logic [255:0] POLY_2_128 = {
    64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
  };
  localparam logic [255:0] POLY_2_192 = {
    64'h39109bb02acbe635, 64'h77710069854ee241,
    64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] bound;
  } req_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = REG_VARIANT;
  logic [63:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [2:0]  kind_i      = KIND_RAW;
  logic [63:0] bound_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] value_o;

  xoshiro256_random_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .bound_i     (bound_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  req_t        pending_q[$];
  logic [63:0] want_values[$];
  int unsigned error_count  = 0;
  int unsigned results_seen = 0;

  // ---------------------------------------------------------------
  // Generator mirror: state words, seed registers, scrambler select
  // ---------------------------------------------------------------
  logic [63:0] st_word  [4];
  logic [63:0] seed_reg [4];
  logic [1:0]  variant_reg;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned k);
    return (x << k) | (x >> (64 - k));
  endfunction

  function automatic void advance_state();
    logic [63:0] t;
    t = st_word[1] << 17;
    st_word[2] ^= st_word[0];
    st_word[3] ^= st_word[1];
    st_word[1] ^= st_word[2];
    st_word[0] ^= st_word[3];
    st_word[2] ^= t;
    st_word[3] = rotl(st_word[3], 45);
  endfunction

  // scramble the current state, then step it
  function automatic logic [63:0] scramble_and_step();
    logic [63:0] r;
    case (variant_reg)
      VAR_PLUS:     r = st_word[0] + st_word[3];
      VAR_PLUSPLUS: r = rotl(st_word[0] + st_word[3], 23) + st_word[0];
      default:      r = rotl(st_word[1] * 64'd5, 7) * 64'd9;  // star-star, also code 3
    endcase
    advance_state();
    return r;
  endfunction

  function automatic int unsigned top_one(input logic [63:0] v);
    for (int i = 63; i > 0; i--) begin
      if (v[i]) return i;
    end
    return 0;
  endfunction

  function automatic void leap(input logic [255:0] poly);
    logic [63:0] acc [4];
    acc = '{default: '0};
    for (int b = 0; b < 256; b++) begin
      if (poly[b]) begin
        for (int k = 0; k < 4; k++) acc[k] ^= st_word[k];
      end
      advance_state();
    end
    st_word = acc;
  endfunction

  function automatic void reseed_state();
    st_word = seed_reg;
    advance_state();
  endfunction

  // expected value word for one request; updates the mirror
  function automatic logic [63:0] model_request(input logic [2:0] kind,
                                                input logic [63:0] bound);
    logic [63:0]  r;
    logic [63:0]  w;
    logic [31:0]  b32;
    logic [31:0]  c32;
    int unsigned  sh;
    r = '0;
    case (kind)
      KIND_RAW: r = scramble_and_step();
      KIND_B64: begin
        if (bound == '0) begin
          r = scramble_and_step();
        end else begin
          sh = 63 - top_one(bound);
          do r = scramble_and_step() >> sh; while (r >= bound);
        end
      end
      KIND_B32: begin
        b32 = bound[31:0];
        if (b32 == '0) begin
          w = scramble_and_step();
          r = {32'd0, w[31:0]};
        end else begin
          sh = 31 - top_one({32'd0, b32});
          do begin
            w   = scramble_and_step();
            c32 = w[31:0] >> sh;
          end while (c32 >= b32);
          r = {32'd0, c32};
        end
      end
      KIND_J128:   leap(POLY_2_128);
      KIND_J192:   leap(POLY_2_192);
      KIND_RESEED: reseed_state();
      default: ;  // undefined kinds leave the state alone
    endcase
    return r;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------
  // Request driver: bursts of words with random gaps
  // ---------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i     <= KIND_RAW;
      bound_i    <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        want_values.push_back(model_request(kind_i, bound_i));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      // slot is free unless a word is still waiting
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          nxt = pending_q.pop_front();
          in_valid_i <= 1'b1;
          kind_i     <= nxt.kind;
          bound_i    <= nxt.bound;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Result receiver: rotating stall patterns plus long hold-offs
  // ---------------------------------------------------------------
  int unsigned rx_cycles  = 0;
  int unsigned hold_left  = 0;
  int unsigned holds_done = 0;

  always @(posedge clk_i or negedge rst_ni) begin : rx_ready
    rx_mode_e mode;
    logic     take;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rx_cycles++;
      if (hold_left > 0) begin
        hold_left--;
      end else if (holds_done < 2 && results_seen >= 300 + holds_done * 800) begin
        hold_left = HOLD_LEN;
        holds_done++;
      end
      mode = rx_mode_e'((rx_cycles >> 7) % 4);
      case (mode)
        RX_OPEN:   take = 1'b1;
        RX_COIN:   take = 1'($urandom_range(0, 1));
        RX_SPARSE: take = (rx_cycles % 4 == 0);
        default:   take = ($urandom_range(0, 3) != 0);
      endcase
      out_ready_i <= take && (hold_left == 0);
    end
  end

  // ---------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------
  always @(posedge clk_i) begin : result_mon
    logic [63:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (want_values.size() == 0) begin
        flag_error($sformatf("unexpected result word value=%h", value_o));
      end else begin
        want = want_values.pop_front();
        if (value_o !== want)
          flag_error($sformatf("value mismatch: got %h want %h", value_o, want));
      end
    end
  end

  // ---------------------------------------------------------------
  // Watchdog: cycles without any handshake
  // ---------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  task automatic queue_req(input logic [2:0] k, input logic [63:0] b);
    pending_q.push_back('{kind: k, bound: b});
  endtask

  // block is idle once nothing is queued, offered or outstanding
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || want_values.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_VARIANT: variant_reg = data[1:0];
      REG_SEED0:   seed_reg[0] = data;
      REG_SEED1:   seed_reg[1] = data;
      REG_SEED2:   seed_reg[2] = data;
      REG_SEED3:   seed_reg[3] = data;
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // bound, zero or with its top set bit spread over the field
  function automatic logic [63:0] pick_bound(input bit narrow);
    logic [63:0] v;
    int unsigned top;
    top = narrow ? 31 : 63;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = ALL_ONES >> (63 - top);
      2:       v = 64'd1 << $urandom_range(0, top);
      default: begin
        top = $urandom_range(0, top);
        v   = (rand64() >> (63 - top)) | (64'd1 << top);
      end
    endcase
    if (narrow) v = {$urandom, v[31:0]};
    return v;
  endfunction

  function automatic logic [63:0] pick_seed();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return ALL_ONES;
      default: return rand64();
    endcase
  endfunction

  initial begin : stimulus
    int unsigned n;
    int unsigned sel;

    variant_reg = VAR_PLUSPLUS;
    seed_reg    = '{64'd1, 64'd0, 64'd0, 64'd0};
    reseed_state();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset state and default config, every kind and bound extreme
    queue_req(KIND_RAW, '0);
    queue_req(KIND_B64, '0);
    queue_req(KIND_B64, 64'd1);
    queue_req(KIND_B64, 64'd3);
    queue_req(KIND_B64, ALL_ONES);
    queue_req(KIND_B64, 64'h8000_0000_0000_0000);
    queue_req(KIND_B32, 64'hFFFF_FFFF_0000_0000);  // low half zero: raw low word
    queue_req(KIND_B32, 64'd1);
    queue_req(KIND_B32, 64'h0000_0000_FFFF_FFFF);
    queue_req(KIND_B32, 64'h5A5A_5A5A_8000_0000);
    queue_req(KIND_J128, rand64());
    queue_req(KIND_J192, rand64());
    queue_req(KIND_RESEED, rand64());
    queue_req(KIND_UNDEF6, rand64());
    queue_req(KIND_UNDEF7, ALL_ONES);
    wait_idle();

    // plus scrambler, extreme seeds, write to an unused index
    write_reg(REG_VARIANT, {62'd0, VAR_PLUS});
    write_reg(REG_SEED0, ALL_ONES);
    write_reg(REG_SEED1, '0);
    write_reg(REG_SEED2, rand64());
    write_reg(REG_SEED3, 64'h8000_0000_0000_0001);
    write_reg(REG_UNUSED, ALL_ONES);
    queue_req(KIND_RESEED, '0);
    queue_req(KIND_RAW, '0);
    wait_idle();

    write_reg(REG_VARIANT, {62'd0, VAR_STARSTAR});
    queue_req(KIND_RAW, '0);
    wait_idle();

    // code 3 behaves as star-star
    write_reg(REG_VARIANT, {ALL_ONES[63:2], VAR_STARSTAR_ALT});
    queue_req(KIND_RAW, '0);
    wait_idle();

    // all-zero state sticks at zero
    for (int i = 0; i < 4; i++) write_reg(3'(REG_SEED0 + i), '0);
    queue_req(KIND_RESEED, '0);
    queue_req(KIND_RAW, '0);
    queue_req(KIND_B64, 64'd5);
    queue_req(KIND_B32, 64'd7);
    wait_idle();

    // random phases, each with its own scrambler and seeds
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(REG_VARIANT, {62'(rand64() >> 2), 2'(phase % 4)});
      for (int i = 0; i < 4; i++) write_reg(3'(REG_SEED0 + i), pick_seed());
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, rand64());
      queue_req(KIND_RESEED, rand64());
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        sel = $urandom_range(0, 99);
        n++;
        if (sel < 30)      queue_req(KIND_RAW, rand64());
        else if (sel < 60) queue_req(KIND_B64, pick_bound(1'b0));
        else if (sel < 85) queue_req(KIND_B32, pick_bound(1'b1));
        else if (sel < 92) queue_req(KIND_RESEED, rand64());
        else if (sel < 94) queue_req(KIND_J128, rand64());
        else if (sel < 96) queue_req(KIND_J192, rand64());
        else begin
          // ignored kinds do not count toward the phase
          queue_req(sel[0] ? KIND_UNDEF7 : KIND_UNDEF6, rand64());
          n--;
        end
      end
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (want_values.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", want_values.size()));
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/xrg_pkg.sv
design/xrg_ctrl.sv
design/xrg_datapath.sv
design/xoshiro256_random_generator.sv
tb/tb_top.sv
